>>> src/gir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gir_pkg
// Shared types and constants of the gray image rmse unit.
// ----------------------------------------------------------------------------
package gir_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 13;
    localparam int SUM_W        = 40;
    localparam int COUNT_W      = 24;
    localparam int FRAC_W       = 17;
    localparam int FRAC_SHIFT   = 32;
    localparam int DIVIDEND_W   = SUM_W + FRAC_SHIFT;
    localparam int QUOT_W       = 64;
    localparam int ROOT_W       = QUOT_W / 2;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int PROD_W       = 2 * ROOT_W;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for any 32-bit x
    localparam logic [ROOT_W-1:0] RECIP_255   = 32'h8080_8081;
    localparam int                RECIP_SHIFT = 39;

    localparam int DEFAULT_MAX_DIM = 4096;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_ACCUM = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SQRT  = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic acc;
        logic div_load;
        logic div_step;
        logic sqrt_step;
        logic mul_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } ctrl_status_t;

endpackage

>>> src/gray_image_rmse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_image_rmse_unit
// Root-mean-square error over 255 between two 8-bit gray images, Q1.16.
// ----------------------------------------------------------------------------
// pixel pairs are taken one per cycle while the image accumulates
// after the last pixel the result goes through the bit-serial divider, the
// square root, the multiply and a hand-off that waits for the output register
// to free up; no pixel is taken meanwhile
// reset clears sum, count and the result handshake; size is 640 x 480
module gray_image_rmse_unit
    import gir_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  logic [PIX_W-1:0]  orig_pixel,
    input  logic [PIX_W-1:0]  ref_pixel,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [FRAC_W-1:0] rmse_fraction
);

    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    ctrl_cmd_t        cmd;
    ctrl_status_t     status;

    gir_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height)
    );

    gir_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    gir_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .image_width   (image_width),
        .image_height  (image_height),
        .orig_pixel    (orig_pixel),
        .ref_pixel     (ref_pixel),
        .cmd           (cmd),
        .status        (status),
        .rmse_fraction (rmse_fraction)
    );

endmodule

>>> src/gir_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gir_regs
// APB-style register file holding the image width and height.
// ----------------------------------------------------------------------------
module gir_regs
    import gir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [CFG_W-1:0]  image_width,
    output logic [CFG_W-1:0]  image_height
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    reg_index_t       index;
    logic             wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (index)
                REG_IMAGE_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

>>> src/gir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gir_ctrl
// Sequencer: accumulate, long divide, square root, scale, hand off result.
// ----------------------------------------------------------------------------
module gir_ctrl
    import gir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pixel_valid,
    output logic         pixel_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign pixel_ready  = (state_reg == ST_ACCUM);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~result_ready;
        cmd            = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                if (pixel_valid)
                begin
                    cmd.acc = 1'b1;
                    if (status.last)
                    begin
                        cmd.div_load = 1'b1;
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/gir_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gir_dp
// Datapath: squared-difference accumulator, radix-2 divider, bit-serial
// square root and reciprocal scaling by 1/255.
// ----------------------------------------------------------------------------
module gir_dp
    import gir_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  image_width,
    input  logic [CFG_W-1:0]  image_height,
    input  logic [PIX_W-1:0]  orig_pixel,
    input  logic [PIX_W-1:0]  ref_pixel,
    input  ctrl_cmd_t         cmd,
    output ctrl_status_t      status,
    output logic [FRAC_W-1:0] rmse_fraction
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int SREM_W = ROOT_W + 2;

    logic [DIM_W-1:0]      width_eff;
    logic [DIM_W-1:0]      height_eff;
    logic [TOT_W-1:0]      total;
    logic [PIX_W-1:0]      diff;
    logic [2*PIX_W-1:0]    diff_sq;
    logic [SUM_W-1:0]      sum_inc;
    logic [COUNT_W:0]      count_inc;

    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [TOT_W-1:0]      rem_reg;
    logic [TOT_W-1:0]      divisor_reg;
    logic [TOT_W:0]        div_part;
    logic                  div_ge;

    logic [SREM_W-1:0]     srem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SREM_W+1:0]     srem_sh;
    logic [SREM_W+1:0]     sqrt_trial;
    logic                  sqrt_ge;

    logic [PROD_W-1:0]     prod_reg;
    logic [FRAC_W-1:0]     result_reg;

    // zero acts as one, oversized values stop at the maximum
    always_comb
    begin
        if (image_width == '0)
            width_eff = DIM_W'(1);
        else if (32'(image_width) > 32'(MAX_DIM))
            width_eff = DIM_W'(MAX_DIM);
        else
            width_eff = DIM_W'(image_width);

        if (image_height == '0)
            height_eff = DIM_W'(1);
        else if (32'(image_height) > 32'(MAX_DIM))
            height_eff = DIM_W'(MAX_DIM);
        else
            height_eff = DIM_W'(image_height);
    end

    assign total     = TOT_W'(width_eff) * TOT_W'(height_eff);
    assign diff      = (orig_pixel >= ref_pixel) ? (orig_pixel - ref_pixel)
                                                 : (ref_pixel - orig_pixel);
    assign diff_sq   = (2*PIX_W)'(diff) * (2*PIX_W)'(diff);
    assign sum_inc   = sum_reg + SUM_W'(diff_sq);
    assign count_inc = {1'b0, count_reg} + 1'b1;

    assign status.last = (64'(count_inc) >= 64'(total));

    // running sum and pixel count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (status.last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_inc;
                count_reg <= count_inc[COUNT_W-1:0];
            end
        end
    end

    // restoring division of sum * 2^32 by total, one quotient bit per cycle;
    // quotient bits shift in at the bottom as dividend bits leave the top
    assign div_part = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign div_ge   = (div_part >= {1'b0, divisor_reg});

    // digit-by-digit square root on the low quotient bits, two bits a step
    assign srem_sh    = {srem_reg, quo_reg[QUOT_W-1 -: 2]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};
    assign sqrt_ge    = (srem_sh >= sqrt_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg     <= {sum_inc, FRAC_SHIFT'(0)};
            rem_reg     <= '0;
            divisor_reg <= total;
            srem_reg    <= '0;
            root_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? TOT_W'(div_part - {1'b0, divisor_reg})
                              : div_part[TOT_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], div_ge};
        end
        else if (cmd.sqrt_step)
        begin
            srem_reg <= sqrt_ge ? SREM_W'(srem_sh - sqrt_trial)
                                : srem_sh[SREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], sqrt_ge};
            quo_reg  <= {quo_reg[DIVIDEND_W-3:0], 2'b00};
        end

        if (cmd.mul_en)
            prod_reg <= PROD_W'(root_reg) * PROD_W'(RECIP_255);

        if (cmd.load_out)
            result_reg <= prod_reg[RECIP_SHIFT +: FRAC_W];
    end

    assign rmse_fraction = result_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gray image rmse unit. Streams pixel pairs over
// valid/ready, sets the image size over the register port, predicts each
// per-image rmse over 255 in Q1.16 and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import gir_pkg::*;

    localparam int DRAIN_CYCLES = 130;   // covers the result latency plus margin
    localparam int MAX_SIDE     = DEFAULT_MAX_DIM;

    // pixel pair styles
    localparam int STYLE_RANDOM = 0;
    localparam int STYLE_EQUAL  = 3;
    localparam int STYLE_SWING  = 4;
    localparam int STYLE_NEAR   = 5;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pixel_valid;
    logic              pixel_ready;
    logic [PIX_W-1:0]  orig_pixel;
    logic [PIX_W-1:0]  ref_pixel;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [FRAC_W-1:0] rmse_fraction;

    // predictor state
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    bit   [SUM_W-1:0]   err_sum;
    bit   [COUNT_W-1:0] pix_taken;
    logic [FRAC_W-1:0]  expected_rmse[$];
    logic [FRAC_W-1:0]  want_rmse;

    int fail_count    = 0;
    int pixels_sent   = 0;
    int results_seen  = 0;
    int size_writes   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    gray_image_rmse_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .orig_pixel    (orig_pixel),
        .ref_pixel     (ref_pixel),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .rmse_fraction (rmse_fraction)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bit [63:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 64'd1;
        if (v > MAX_SIDE)
            return 64'(MAX_SIDE);
        return 64'(v);
    endfunction

    // truncated square root, one result bit per pass from the top
    function automatic bit [63:0] floor_sqrt(input bit [63:0] x);
        bit [63:0] root;
        bit [63:0] trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic void predict_rmse(input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b);
        bit [63:0] diff;
        bit [63:0] total;
        bit [63:0] whole;
        bit [63:0] part;
        bit [63:0] mse_q32;
        diff = (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
        total = eff_dim(width_reg) * eff_dim(height_reg);
        err_sum = SUM_W'(64'(err_sum) + diff * diff);
        if (64'(pix_taken) + 64'd1 < total)
        begin
            pix_taken = pix_taken + 1'b1;
            return;
        end
        whole = 64'(err_sum) / total;
        part = 64'(err_sum) % total;
        mse_q32 = (whole << FRAC_SHIFT) + ((part << FRAC_SHIFT) / total);
        expected_rmse.push_back(FRAC_W'(floor_sqrt(mse_q32) / 64'd255));
        err_sum = 0;
        pix_taken = 0;
    endfunction

    task automatic note_fail(input string what, input logic [FRAC_W-1:0] want,
                             input logic [FRAC_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("error at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_rmse.size() == 0)
                note_fail("result with none pending", '0, rmse_fraction);
            else
            begin
                want_rmse = expected_rmse.pop_front();
                if (rmse_fraction !== want_rmse)
                    note_fail("rmse_fraction mismatch", want_rmse, rmse_fraction);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        orig_pixel  <= a;
        ref_pixel   <= b;
        do
            @(posedge clk);
        while (!pixel_ready);
        predict_rmse(a, b);
        pixels_sent++;
    endtask

    task automatic send_styled_pixel(input int style);
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        a = PIX_W'($urandom);
        case (style)
            STYLE_EQUAL: b = a;
            STYLE_SWING:
            begin
                a = {PIX_W{a[0]}};
                b = ~a;
            end
            STYLE_NEAR: b = a ^ PIX_W'($urandom_range(0, 3));
            default: b = PIX_W'($urandom);
        endcase
        send_pixel(a, b);
    endtask

    // drop valid, let every pending result drain, then give the block time
    // to finish any image that ends without a result
    task automatic wait_quiet();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (expected_rmse.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper bits are junk that the register must drop
        pwdata  <= {DATA_W'($urandom) & ~DATA_W'({CFG_W{1'b1}})} | DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        size_writes++;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_quiet();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_pixel_extremes();
        set_size(1, 1);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd128, 8'd127);
        send_pixel(8'd1, 8'd0);
        send_pixel(8'hAA, 8'h55);
        send_pixel(8'h55, 8'hAA);
        // half the pixels at full swing gives the square root of one half
        set_size(2, 2);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd7, 8'd7);
        send_pixel(8'd200, 8'd200);
    endtask

    task automatic test_zero_size();
        set_size(0, 3);
        send_pixel(8'd10, 8'd20);
        send_pixel(8'd30, 8'd0);
        send_pixel(8'd90, 8'd91);
        set_size(0, 0);
        send_pixel(8'd17, 8'd240);
        send_pixel(8'd64, 8'd63);
        set_size(5, 0);
        repeat (5) send_styled_pixel(STYLE_RANDOM);
    endtask

    // oversized and maximum sizes must not close the image early;
    // a shrink afterwards closes it with everything taken so far
    task automatic test_oversize();
        set_size(13'h1FFF, 0);
        repeat (24) send_styled_pixel(STYLE_SWING);
        set_size(0, 13'(MAX_SIDE + 1));
        repeat (24) send_styled_pixel(STYLE_RANDOM);
        set_size(13'(MAX_SIDE), 13'(MAX_SIDE));
        repeat (8) send_styled_pixel(STYLE_NEAR);
        set_size(7, 7);
        send_styled_pixel(STYLE_RANDOM);
    endtask

    task automatic test_resize_mid_image();
        set_size(4, 4);
        repeat (6) send_styled_pixel(STYLE_RANDOM);
        // shrink below the count already taken: next pixel closes the image
        set_size(2, 2);
        send_styled_pixel(STYLE_RANDOM);
        set_size(2, 1);
        send_styled_pixel(STYLE_RANDOM);
        // grow before the image is done
        set_size(3, 1);
        send_styled_pixel(STYLE_NEAR);
        send_styled_pixel(STYLE_RANDOM);
    endtask

    task automatic test_random_images();
        int phase;
        int sent;
        int w;
        int h;
        int total;
        int images;
        int style;
        int k;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 230)
            begin
                if ($urandom_range(9) == 0)
                begin
                    w = $urandom_range(7, 64);
                    h = $urandom_range(0, 1);
                end
                else
                begin
                    w = $urandom_range(0, 6);
                    h = $urandom_range(0, 6);
                end
                set_size(CFG_W'(w), CFG_W'(h));
                total = int'(eff_dim(CFG_W'(w)) * eff_dim(CFG_W'(h)));
                images = $urandom_range(1, 3);
                repeat (images)
                begin
                    style = $urandom_range(0, 5);
                    repeat (total) send_styled_pixel(style);
                end
                sent += images * total;
                // partial image, so the next size lands mid-image
                if (total > 1 && $urandom_range(7) == 0)
                begin
                    k = $urandom_range(1, total - 1);
                    repeat (k) send_styled_pixel(STYLE_RANDOM);
                    sent += k;
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pixel_valid = 1'b0;
        orig_pixel  = '0;
        ref_pixel   = '0;
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        err_sum     = 0;
        pix_taken   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_extremes();
        test_zero_size();
        test_oversize();
        test_resize_mid_image();
        test_random_images();

        wait_quiet();
        $display("sent %0d pixel items over %0d size register writes", pixels_sent,
                 size_writes);
        $display("checked %0d rmse results, %0d failures", results_seen, fail_count);
        if (fail_count == 0 && expected_rmse.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results still pending", expected_rmse.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
